>>> src/vlmf_pkg.sv
package vlmf_pkg;

    // Field widths fixed by the item formats
    localparam int COUNT_W = 19;
    localparam int INDEX_W = 18;
    localparam int RGBA_W  = 32;
    localparam int COORD_W = 16;
    localparam int CHAN_W  = 8;

    // Default build parameters
    localparam int MAX_STEPS_DEF   = 128;
    localparam int GRID_BITS_DEF   = 6;
    localparam int VOXEL_DEPTH_DEF = 262144;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic [INDEX_W-1:0]         voxel_index;
        logic [RGBA_W-1:0]          voxel_rgba;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  start_z;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic signed [COORD_W-1:0]  end_z;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              hit;
    } t_out;

endpackage

>>> src/voxel_line_march_fog_top.sv
// Voxel line march with distance fog.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes write and trace
// transactions; a transaction is taken when valid is high and stall is low.
// A write stores one RGBA word in the voxel store when its index is in range
// and gives no result. A trace walks a 3D Bresenham line one point per cycle
// through the store read port; the block stalls its input until the trace has
// handed its result on. A trace passes two setup states (S_SETUP, S_INIT),
// then issues one read per point with its data checked in the cycle after;
// a hit then runs four phases per colour channel on the shared fog multiplier.
// Output channel (o_out_valid / i_out_stall / o_out_data) is fed from an
// output register; a stalled result holds, and the next transaction may be
// taken while it waits. Configuration (i_cfg_valid / o_cfg_ready) writes
// voxel_count and is always ready. Reset clears voxel_count and all control
// state; store contents are undefined until written.
module voxel_line_march_fog_top #(
    parameter int MAX_STEPS   = vlmf_pkg::MAX_STEPS_DEF,
    parameter int GRID_BITS   = vlmf_pkg::GRID_BITS_DEF,
    parameter int VOXEL_DEPTH = vlmf_pkg::VOXEL_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  vlmf_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output vlmf_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vlmf_pkg::COUNT_W-1:0]  i_cfg_data
);

    localparam int KW = $clog2(MAX_STEPS + 1);
    localparam int AW = $clog2(VOXEL_DEPTH);

    logic [vlmf_pkg::COUNT_W-1:0] r_count;
    logic                         r_out_valid;
    vlmf_pkg::t_out               r_out;

    logic                         w_idle;
    logic                         w_accept;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [vlmf_pkg::RGBA_W-1:0]  w_wdata;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;
    logic [vlmf_pkg::RGBA_W-1:0]  w_rdata;
    logic                         w_fog_start;
    logic [23:0]                  w_fog_rgb_in;
    logic [KW-1:0]                w_fog_k;
    logic                         w_fog_done;
    logic [23:0]                  w_fog_rgb_out;
    logic                         w_res_valid;
    vlmf_pkg::t_out               w_res;
    logic                         w_res_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_idle;
    assign w_accept    = i_in_valid && w_idle;
    assign w_res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (w_res_ready) begin
                r_out_valid <= w_res_valid;
            end
        end
    end

    // Load the output register with a result whenever it is free or being taken
    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    vlmf_store #(
        .VOXEL_DEPTH (VOXEL_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    vlmf_fog #(
        .MAX_STEPS (MAX_STEPS)
    ) u_fog (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fog_start),
        .i_rgb   (w_fog_rgb_in),
        .i_k     (w_fog_k),
        .o_done  (w_fog_done),
        .o_rgb   (w_fog_rgb_out)
    );

    vlmf_march #(
        .MAX_STEPS   (MAX_STEPS),
        .GRID_BITS   (GRID_BITS),
        .VOXEL_DEPTH (VOXEL_DEPTH)
    ) u_march (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_data),
        .o_idle      (w_idle),
        .i_count     (r_count),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_fog_start (w_fog_start),
        .o_fog_rgb   (w_fog_rgb_in),
        .o_fog_k     (w_fog_k),
        .i_fog_done  (w_fog_done),
        .i_fog_rgb   (w_fog_rgb_out),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

endmodule

>>> src/vlmf_store.sv
module vlmf_store #(
    parameter int VOXEL_DEPTH = vlmf_pkg::VOXEL_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(VOXEL_DEPTH)-1:0] i_waddr,
    input  logic [vlmf_pkg::RGBA_W-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(VOXEL_DEPTH)-1:0] i_raddr,
    output logic [vlmf_pkg::RGBA_W-1:0]   o_rdata
);

    logic [vlmf_pkg::RGBA_W-1:0] r_mem [VOXEL_DEPTH];
    logic [vlmf_pkg::RGBA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/vlmf_fog.sv
module vlmf_fog #(
    parameter int MAX_STEPS = vlmf_pkg::MAX_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [23:0]                       i_rgb,
    input  logic [$clog2(MAX_STEPS+1)-1:0]    i_k,
    output logic                              o_done,
    output logic [23:0]                       o_rgb
);

    localparam int KW = $clog2(MAX_STEPS + 1);
    localparam int VW = vlmf_pkg::CHAN_W + KW;
    // floor(2^VW / MAX_STEPS); the quotient estimate is at most one short
    localparam logic [VW:0] RECIP = (VW + 1)'((64'd1 << VW) / 64'(MAX_STEPS));

    localparam logic [1:0] PH_SCALE = 2'd0;
    localparam logic [1:0] PH_RECIP = 2'd1;
    localparam logic [1:0] PH_BACK  = 2'd2;
    localparam logic [1:0] PH_FIX   = 2'd3;

    logic          r_busy;
    logic          r_done;
    logic [1:0]    r_ph;
    logic [1:0]    r_ch;
    logic [23:0]   r_rgb;
    logic [KW-1:0] r_k;
    logic [2*VW:0] r_prod;
    logic [VW-1:0] r_v;
    logic [7:0]    r_q;
    logic [23:0]   r_res;

    logic [7:0]    w_c;
    logic [VW-1:0] w_a;
    logic [VW:0]   w_b;
    logic [2*VW:0] w_prod;
    logic [VW-1:0] w_rem;
    logic [7:0]    w_q;

    assign w_c = r_rgb[{r_ch, 3'b000} +: 8];

    // Operand select for the shared multiplier
    always_comb begin
        unique case (r_ph)
            PH_SCALE: begin
                w_a = VW'(8'd255 - w_c);
                w_b = (VW + 1)'(r_k);
            end
            PH_RECIP: begin
                w_a = r_prod[VW-1:0];
                w_b = RECIP;
            end
            PH_BACK: begin
                w_a = VW'(r_prod[VW +: 8]);
                w_b = (VW + 1)'(MAX_STEPS);
            end
            PH_FIX: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = (2 * VW + 1)'(w_a) * (2 * VW + 1)'(w_b);
    assign w_rem  = r_v - r_prod[VW-1:0];
    assign w_q    = r_q + 8'(w_rem >= VW'(MAX_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_SCALE;
            r_ch   <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= PH_SCALE;
                r_ch   <= 2'd0;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == PH_FIX) begin
                    if (r_ch == 2'd2) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rgb <= i_rgb;
            r_k   <= i_k;
        end
        r_prod <= w_prod;
        if (r_ph == PH_RECIP) begin
            r_v <= r_prod[VW-1:0];
        end
        if (r_ph == PH_BACK) begin
            r_q <= r_prod[VW +: 8];
        end
        if (r_busy && r_ph == PH_FIX) begin
            r_res[{r_ch, 3'b000} +: 8] <= w_c + w_q;
        end
    end

    assign o_done = r_done;
    assign o_rgb  = r_res;

endmodule

>>> src/vlmf_march.sv
module vlmf_march #(
    parameter int MAX_STEPS   = vlmf_pkg::MAX_STEPS_DEF,
    parameter int GRID_BITS   = vlmf_pkg::GRID_BITS_DEF,
    parameter int VOXEL_DEPTH = vlmf_pkg::VOXEL_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  vlmf_pkg::t_in                     i_item,
    output logic                              o_idle,
    input  logic [vlmf_pkg::COUNT_W-1:0]      i_count,
    output logic                              o_we,
    output logic [$clog2(VOXEL_DEPTH)-1:0]    o_waddr,
    output logic [vlmf_pkg::RGBA_W-1:0]       o_wdata,
    output logic                              o_re,
    output logic [$clog2(VOXEL_DEPTH)-1:0]    o_raddr,
    input  logic [vlmf_pkg::RGBA_W-1:0]       i_rdata,
    output logic                              o_fog_start,
    output logic [23:0]                       o_fog_rgb,
    output logic [$clog2(MAX_STEPS+1)-1:0]    o_fog_k,
    input  logic                              i_fog_done,
    input  logic [23:0]                       i_fog_rgb,
    output logic                              o_res_valid,
    output vlmf_pkg::t_out                    o_res,
    input  logic                              i_res_ready
);

    localparam int KW  = $clog2(MAX_STEPS + 1);
    localparam int AW  = $clog2(VOXEL_DEPTH);
    localparam int MW  = 3 * GRID_BITS;
    localparam int CW0 = (MW > vlmf_pkg::COUNT_W) ? MW : vlmf_pkg::COUNT_W;
    localparam int CW  = (CW0 > AW + 1) ? CW0 : AW + 1;
    localparam int WCW = (vlmf_pkg::INDEX_W > AW + 1) ? vlmf_pkg::INDEX_W : AW + 1;
    localparam int PW  = vlmf_pkg::COORD_W;
    localparam int EW  = PW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_MARCH = 3'd3;
    localparam logic [2:0] S_FOG   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic                 r_issue;
    logic                 r_pend;
    logic                 r_pend_empty;
    logic                 r_pend_last;
    logic [KW-1:0]        r_pend_k;
    logic [KW-1:0]        r_k;
    logic [KW-1:0]        r_n;
    logic [PW-1:0]        r_dm;
    logic [7:0]           r_alpha;
    vlmf_pkg::t_out       r_res;

    logic signed [PW-1:0] r_p   [3];
    logic signed [PW-1:0] r_e   [3];
    logic [PW-1:0]        r_d   [3];
    logic                 r_pos [3];
    logic signed [EW-1:0] r_er  [3];

    logic signed [EW-1:0] w_dif  [3];
    logic signed [EW-1:0] w_ern  [3];
    logic [2:0]           w_grid;
    logic [MW-1:0]        w_idx;
    logic [CW-1:0]        w_idx_ext;
    logic                 w_empty;
    logic [WCW-1:0]       w_wext;
    logic [PW-1:0]        w_dm;
    logic [KW-1:0]        w_n;
    logic                 w_hit;

    // Per-axis difference, error update and grid test
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_dif[a]  = EW'(r_e[a]) - EW'(r_p[a]);
            w_ern[a]  = r_er[a] - $signed({1'b0, r_d[a]});
            w_grid[a] = (r_p[a][PW-1:GRID_BITS] == '0);
        end
    end

    // Morton interleave, x in the lowest bit
    always_comb begin
        for (int b = 0; b < GRID_BITS; b++) begin
            for (int a = 0; a < 3; a++) begin
                w_idx[3*b+a] = r_p[a][b];
            end
        end
    end

    assign w_idx_ext = CW'(w_idx);
    assign w_empty   = !(&w_grid) || (w_idx_ext >= CW'(i_count)) ||
                       (w_idx_ext >= CW'(VOXEL_DEPTH));

    always_comb begin
        w_dm = r_d[0];
        if (r_d[1] > w_dm) begin
            w_dm = r_d[1];
        end
        if (r_d[2] > w_dm) begin
            w_dm = r_d[2];
        end
    end

    assign w_n = (w_dm < PW'(MAX_STEPS)) ? KW'(w_dm) : KW'(MAX_STEPS);

    assign w_hit = r_pend && !r_pend_empty && (i_rdata[31:24] != 8'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && i_item.opcode == vlmf_pkg::OP_TRACE) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = S_INIT;
            S_INIT:  n_state = S_MARCH;
            S_MARCH: begin
                if (w_hit) begin
                    n_state = S_FOG;
                end else if (r_pend && r_pend_last) begin
                    n_state = S_DONE;
                end
            end
            S_FOG: begin
                if (i_fog_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_MARCH) && r_issue && (n_state == S_MARCH);
            if (r_state == S_INIT) begin
                r_issue <= 1'b1;
            end else if (r_state == S_MARCH) begin
                // drop the issue stream on the last step or once the march ends
                if ((r_k == r_n) || (n_state != S_MARCH)) begin
                    r_issue <= 1'b0;
                end
            end else begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_p[0] <= i_item.start_x;
                r_p[1] <= i_item.start_y;
                r_p[2] <= i_item.start_z;
                r_e[0] <= i_item.end_x;
                r_e[1] <= i_item.end_y;
                r_e[2] <= i_item.end_z;
            end
            S_SETUP: begin
                for (int a = 0; a < 3; a++) begin
                    r_d[a]   <= w_dif[a][EW-1] ? PW'(-w_dif[a]) : w_dif[a][PW-1:0];
                    r_pos[a] <= r_p[a] < r_e[a];
                end
            end
            S_INIT: begin
                r_dm <= w_dm;
                r_n  <= w_n;
                r_k  <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_er[a] <= EW'(w_n >> 1);
                end
            end
            S_MARCH: begin
                if (r_issue) begin
                    r_pend_empty <= w_empty;
                    r_pend_k     <= r_k;
                    r_pend_last  <= (r_k == r_n);
                    if (r_k != r_n) begin
                        r_k <= r_k + KW'(1);
                    end
                    for (int a = 0; a < 3; a++) begin
                        if (w_ern[a] < 0) begin
                            r_er[a] <= w_ern[a] + $signed({1'b0, r_dm});
                            r_p[a]  <= r_pos[a] ? r_p[a] + 16'sd1 : r_p[a] - 16'sd1;
                        end else begin
                            r_er[a] <= w_ern[a];
                        end
                    end
                end
                if (w_hit) begin
                    r_alpha <= i_rdata[31:24];
                end else if (r_pend && r_pend_last) begin
                    r_res <= '{red: 8'hFF, green: 8'hFF, blue: 8'hFF,
                               alpha: 8'hFF, hit: 1'b0};
                end
            end
            S_FOG: begin
                if (i_fog_done) begin
                    r_res <= '{red: i_fog_rgb[7:0], green: i_fog_rgb[15:8],
                               blue: i_fog_rgb[23:16], alpha: r_alpha, hit: 1'b1};
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign w_wext  = WCW'(i_item.voxel_index);
    assign o_we    = i_accept && (i_item.opcode == vlmf_pkg::OP_WRITE) &&
                     (w_wext < WCW'(VOXEL_DEPTH));
    assign o_waddr = w_wext[AW-1:0];
    assign o_wdata = i_item.voxel_rgba;

    assign o_re    = (r_state == S_MARCH) && r_issue;
    assign o_raddr = w_idx_ext[AW-1:0];

    assign o_fog_start = (r_state == S_MARCH) && w_hit;
    assign o_fog_rgb   = i_rdata[23:0];
    assign o_fog_k     = r_pend_k;

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_pend_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(o_re))
        else $error("read data checked without a matching read");

    a_no_read_past_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_pend_last) |=> !r_pend)
        else $error("read issued beyond the last step");

    a_fog_follows_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fog_start |=> (r_state == S_FOG))
        else $error("fog started without entering the fog state");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("result changed before hand-off");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == S_IDLE) && !r_issue)
        else $error("store written during a march");

endmodule
